@@ rtl/core/beq_pkg.sv @@
`timescale 1ns / 1ps
package beq_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int FRAC_SH  = 28;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam logic signed [31:0] SAMPLE_MAX = 32'sd8388607;
  localparam logic signed [31:0] SAMPLE_MIN = -32'sd8388608;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef struct packed {
    coef_t a2;
    coef_t a1;
    coef_t b2;
    coef_t b1;
    coef_t b0;
  } coef_row_t;

  typedef struct packed {
    sample_t y2;
    sample_t y1;
    sample_t x2;
    sample_t x1;
  } hist_t;

  typedef struct packed {
    logic mul_en;
    logic add_en;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MUL,
    ST_ADD,
    ST_SAT
  } state_e;

  localparam int CROW_W = $bits(coef_row_t);
  localparam int HIST_W = $bits(hist_t);

endpackage

@@ rtl/core/beq_ram.sv @@
`timescale 1ns / 1ps
module beq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/beq_mac.sv @@
`timescale 1ns / 1ps
module beq_mac (
  input  logic                  clk_i,
  input  beq_pkg::mac_ctrl_t    ctrl_i,
  input  beq_pkg::coef_row_t    coef_i,
  input  beq_pkg::hist_t        hist_i,
  input  beq_pkg::sample_t      x_i,
  output beq_pkg::sample_t      y_o
);
  import beq_pkg::*;

  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q, p3_q, p4_q;
  logic signed [ACC_W-1:0]  sa_q, sb_q;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    rnd;
  logic signed [31:0]       q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p0_q <= coef_i.b0 * x_i;
      p1_q <= coef_i.b1 * hist_i.x1;
      p2_q <= coef_i.b2 * hist_i.x2;
      p3_q <= coef_i.a1 * hist_i.y1;
      p4_q <= coef_i.a2 * hist_i.y2;
    end
    if (ctrl_i.add_en) begin
      sa_q <= ACC_W'(p0_q) + ACC_W'(p1_q) + ACC_W'(p2_q);
      sb_q <= ACC_W'(p3_q) + ACC_W'(p4_q);
    end
  end

  // round half up to Q1.23, then clamp
  always_comb begin
    acc = sa_q - sb_q;
    rnd = (ACC_W + 1)'(acc) + (ACC_W + 1)'(64'sd1 <<< (FRAC_SH - 1));
    q   = 32'(rnd >>> FRAC_SH);
    if (q > SAMPLE_MAX) begin
      y_o = SAMPLE_W'(SAMPLE_MAX);
    end else if (q < SAMPLE_MIN) begin
      y_o = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      y_o = SAMPLE_W'(q);
    end
  end

endmodule

@@ rtl/core/biquad_cascade_equalizer.sv @@
`timescale 1ns / 1ps
// channel | transfer when          | payload
// --------+------------------------+-------------------------------------------------
// in      | in_valid_i & !in_stall_o | operation, sample_in, section_sel, coef_sel,
//         |                        | coef_value
// out     | out_valid_o & !out_stall_i | sample_out
//
// A sample is processed one section at a time: per section one memory read, then
// multiply, add and round/saturate through the shared MAC; the x dependency
// between sections sets this order. A coefficient write is a read-modify-write of
// the section's coefficient row; an ignored write does not leave idle. Reset clears
// per-row valid bits, so both memories read as zero until written; no clearing pass.
// The input stalls while an item is in progress; a finished sample waits in the output
// register and only the end of the following sample waits on out_stall_i.
module biquad_cascade_equalizer #(
  parameter int SECTIONS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  beq_pkg::sample_t        sample_in_i,
  input  logic [2:0]              section_sel_i,
  input  logic [2:0]              coef_sel_i,
  input  beq_pkg::coef_t          coef_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output beq_pkg::sample_t        sample_out_o
);
  import beq_pkg::*;

  localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [SW-1:0] LAST_SEC = SW'(SECTIONS - 1);

  state_e               state_q, state_d;
  logic [SW-1:0]        k_q, k_d;
  sample_t              x_q, x_d;
  hist_t                st_q, st_d;
  logic [SW-1:0]        wsec_q, wsec_d;
  logic [2:0]           wslot_q, wslot_d;
  coef_t                wval_q, wval_d;
  logic [SECTIONS-1:0]  cvalid_q, cvalid_d;
  logic [SECTIONS-1:0]  svalid_q, svalid_d;
  logic                 out_valid_q, out_valid_d;
  sample_t              out_q, out_d;

  logic                 accept, wr_ok, last, hold;
  logic                 rd_en;
  logic [SW-1:0]        rd_addr;
  logic                 coef_we, hist_we;
  coef_row_t            coef_wrow, coef_base, coef_row;
  hist_t                hist_wrow, hist_row;
  logic [CROW_W-1:0]    coef_rdata;
  logic [HIST_W-1:0]    hist_rdata;
  mac_ctrl_t            mac_ctrl;
  sample_t              y;

  assign accept = in_valid_i && !in_stall_o;
  assign wr_ok  = (int'(section_sel_i) < SECTIONS) && (coef_sel_i <= SLOT_A2);
  assign last   = (k_q == LAST_SEC);
  assign hold   = last && out_valid_q && out_stall_i;

  assign coef_base = cvalid_q[wsec_q] ? coef_row_t'(coef_rdata) : '0;
  assign coef_row  = cvalid_q[k_q] ? coef_row_t'(coef_rdata) : '0;
  assign hist_row  = svalid_q[k_q] ? hist_t'(hist_rdata) : '0;

  beq_ram #(
    .WIDTH(CROW_W),
    .DEPTH(SECTIONS)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(wsec_q),
    .wdata_i(coef_wrow),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(coef_rdata)
  );

  beq_ram #(
    .WIDTH(HIST_W),
    .DEPTH(SECTIONS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(k_q),
    .wdata_i(hist_wrow),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(hist_rdata)
  );

  beq_mac u_mac (
    .clk_i (clk_i),
    .ctrl_i(mac_ctrl),
    .coef_i(coef_row),
    .hist_i(st_d),
    .x_i   (x_q),
    .y_o   (y)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_WRITE) begin
            state_d = wr_ok ? ST_WRITE : ST_IDLE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_SAT;
      ST_SAT: begin
        if (!last) begin
          state_d = ST_MUL;
        end else if (!hold) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    k_d         = k_q;
    x_d         = x_q;
    st_d        = st_q;
    wsec_d      = wsec_q;
    wslot_d     = wslot_q;
    wval_d      = wval_q;
    cvalid_d    = cvalid_q;
    svalid_d    = svalid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    coef_we     = 1'b0;
    hist_we     = 1'b0;
    coef_wrow   = coef_base;
    hist_wrow   = '{y2: st_q.y1, y1: y, x2: st_q.x1, x1: x_q};
    mac_ctrl    = '{mul_en: 1'b0, add_en: 1'b0};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_WRITE) begin
            if (wr_ok) begin
              rd_en   = 1'b1;
              rd_addr = SW'(section_sel_i);
              wsec_d  = SW'(section_sel_i);
              wslot_d = coef_sel_i;
              wval_d  = coef_value_i;
            end
          end else begin
            rd_en = 1'b1;
            k_d   = '0;
            x_d   = sample_in_i;
          end
        end
      end
      ST_WRITE: begin
        coef_we = 1'b1;
        cvalid_d[wsec_q] = 1'b1;
        case (wslot_q)
          SLOT_B0: coef_wrow.b0 = wval_q;
          SLOT_B1: coef_wrow.b1 = wval_q;
          SLOT_B2: coef_wrow.b2 = wval_q;
          SLOT_A1: coef_wrow.a1 = wval_q;
          SLOT_A2: coef_wrow.a2 = wval_q;
          default: ;
        endcase
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        st_d = hist_row;
      end
      ST_ADD: begin
        mac_ctrl.add_en = 1'b1;
        if (!last) begin
          rd_en   = 1'b1;
          rd_addr = k_q + SW'(1);
        end
      end
      ST_SAT: begin
        if (!hold) begin
          hist_we = 1'b1;
          svalid_d[k_q] = 1'b1;
          x_d = y;
          if (last) begin
            out_valid_d = 1'b1;
            out_d       = y;
          end else begin
            k_d = k_q + SW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      cvalid_q    <= '0;
      svalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      cvalid_q    <= cvalid_d;
      svalid_q    <= svalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    st_q    <= st_d;
    wsec_q  <= wsec_d;
    wslot_q <= wslot_d;
    wval_q  <= wval_d;
    out_q   <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

`ifndef NO_ASSERTIONS
  a_out_from_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SAT) && $past(last))
    else $error("result raised outside the final section");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (operation_i == OP_SAMPLE) |=> (state_q == ST_MUL) && (k_q == '0))
    else $error("sample transfer did not start at the first section");

  a_hold_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SAT) && hold |-> !hist_we && (state_d == ST_SAT))
    else $error("history written while result is blocked");
`endif

endmodule
